/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the Roman numeral core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// cond must never be true
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

/* src/i2r_pkg.sv */
// ----------------------------------------------------------------------------
// i2r_pkg
// Types, symbol codes and digit pattern helpers for the Roman numeral core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 4;  // thousands, hundreds, tens, units
  localparam int unsigned ValueW    = 12;
  localparam int unsigned SymW      = 8;

  typedef logic [DigitW-1:0] digit_t;

  // one classified value: digit 0 is thousands
  typedef struct packed {
    logic                    err;
    digit_t [NumDigits-1:0]  dig;
  } item_t;

  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_FIVE,
    KIND_TEN
  } kind_e;

  localparam logic [SymW-1:0] ChNone = 8'h00;
  localparam logic [SymW-1:0] ChI    = 8'h49;
  localparam logic [SymW-1:0] ChV    = 8'h56;
  localparam logic [SymW-1:0] ChX    = 8'h58;
  localparam logic [SymW-1:0] ChL    = 8'h4C;
  localparam logic [SymW-1:0] ChC    = 8'h43;
  localparam logic [SymW-1:0] ChD    = 8'h44;
  localparam logic [SymW-1:0] ChM    = 8'h4D;

  // number of characters a decimal digit expands to
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] len;
    case (d) inside
      4'd1, 4'd5:             len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
      4'd3, 4'd7:             len = 3'd3;
      4'd8:                   len = 3'd4;
      default:                len = 3'd0;
    endcase
    return len;
  endfunction

  // which symbol of the position is character j of digit d
  function automatic kind_e digit_kind(input digit_t d, input logic [1:0] j);
    kind_e k;
    if (d == 4'd4) begin
      k = (j == 2'd0) ? KIND_ONE : KIND_FIVE;
    end else if (d == 4'd9) begin
      k = (j == 2'd0) ? KIND_ONE : KIND_TEN;
    end else if (d >= 4'd5) begin
      k = (j == 2'd0) ? KIND_FIVE : KIND_ONE;
    end else begin
      k = KIND_ONE;
    end
    return k;
  endfunction

  // ASCII symbol for a decimal position (0 = thousands) and symbol kind
  function automatic logic [SymW-1:0] symbol_of(input logic [1:0] pos, input kind_e k);
    logic [SymW-1:0] s;
    s = ChNone;
    case (pos)
      2'd0: begin
        if (k == KIND_ONE) s = ChM;
      end
      2'd1: begin
        case (k)
          KIND_ONE:  s = ChC;
          KIND_FIVE: s = ChD;
          KIND_TEN:  s = ChM;
          default:   s = ChNone;
        endcase
      end
      2'd2: begin
        case (k)
          KIND_ONE:  s = ChX;
          KIND_FIVE: s = ChL;
          KIND_TEN:  s = ChC;
          default:   s = ChNone;
        endcase
      end
      default: begin
        case (k)
          KIND_ONE:  s = ChI;
          KIND_FIVE: s = ChV;
          KIND_TEN:  s = ChX;
          default:   s = ChNone;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/integer_to_roman_numeral_core.sv */
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_core
// Converts a 12-bit unsigned integer into its Roman numeral, streamed as
// ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
// A value is taken on a rising edge with start high and busy low. Values
// 1..3999 come back as a run of characters (I V X L C D M), one per strobe,
// with last_o set on the final one; anything else (zero or 4000 and up)
// gives a single strobe with symbol_o = 0, last_o = 1 and error_o = 1.
// The receiver has no way to stall: every strobe is one-cycle data and must
// be captured when it appears. Results come out in the order the values
// were taken. The input register is loaded at the accepting edge; the value
// then passes two more digit-split stages, the queue, the sequencer and
// the output register before its first character reaches the output ports.
// The character sequencer produces one character per cycle while it holds a
// value and moves straight on to the next queued value; an error or a
// one-character numeral gives one character, and the longest numeral, for
// 3888, has 15 characters. That sequencer sets the sustained rate; busy
// rises only when the queue and the front stages are all full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_to_roman_numeral_core import i2r_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   strobe_o,
  output logic [SymW-1:0]        symbol_o,
  output logic                   last_o,
  output logic                   error_o
);

  logic  in_ready;
  logic  q_push, q_full, q_pop, q_avail;
  item_t q_wdata, q_rdata;

  assign busy = !in_ready;

  // front: range check and decimal split, thousands, hundreds, then tens and units together
  i2r_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start),
    .value_i    (value_i),
    .in_ready_o (in_ready),
    .push_o     (q_push),
    .item_o     (q_wdata),
    .full_i     (q_full)
  );

  // decoupling queue, transfers one classified value per push/pop
  i2r_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .avail_o (q_avail)
  );

  // back: character sequencer and output register
  i2r_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (q_avail),
    .item_i   (q_rdata),
    .pop_o    (q_pop),
    .strobe_o (strobe_o),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .error_o  (error_o)
  );

  // an error transfer is a single, empty result
  `ASSERT_IMPLY(a_err_single, clk_i, rst_ni, strobe_o && error_o, last_o && (symbol_o == ChNone))
  // a good numeral never carries a null character
  `ASSERT_IMPLY(a_sym_valid, clk_i, rst_ni, strobe_o && !error_o, symbol_o != ChNone)
  // the front never writes into a full queue
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, q_push && q_full && !q_pop)
  // a pop only happens with something queued
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, q_pop && !q_avail)

endmodule

`default_nettype wire

/* src/i2r_front.sv */
// ----------------------------------------------------------------------------
// i2r_front
// Accepts values, range-checks them and splits them into decimal digits:
// thousands and hundreds in their own pipeline stages, tens and units together.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_front import i2r_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   in_ready_o,
  output logic                   push_o,
  output item_t                  item_o,
  input  wire logic              full_i
);

  // stage valids
  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;

  // stage 0: raw value
  logic [ValueW-1:0] val0_q;
  logic              err0;
  digit_t            th0;
  logic [ValueW-1:0] sub0;

  // stage 1: thousands + remainder below 1000
  logic       err1_q;
  digit_t     th1_q;
  logic [9:0] rem1_q;
  digit_t     hu1;
  logic [9:0] sub1;

  // stage 2: thousands, hundreds + remainder below 100
  logic       err2_q;
  digit_t     th2_q, hu2_q;
  logic [6:0] rem2_q;
  digit_t     te2;
  logic [6:0] sub2;

  assign rdy2       = !v2_q || !full_i;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;
  assign push_o     = v2_q && !full_i;

  assign err0 = (val0_q == '0) || (val0_q > 12'd3999);

  always_comb begin
    th0  = '0;
    sub0 = '0;
    for (int k = 1; k < 4; k++) begin
      if (val0_q >= ValueW'(k * 1000)) begin
        th0  = DigitW'(k);
        sub0 = ValueW'(k * 1000);
      end
    end
  end

  always_comb begin
    hu1  = '0;
    sub1 = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem1_q >= 10'(k * 100)) begin
        hu1  = DigitW'(k);
        sub1 = 10'(k * 100);
      end
    end
  end

  always_comb begin
    te2  = '0;
    sub2 = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem2_q >= 7'(k * 10)) begin
        te2  = DigitW'(k);
        sub2 = 7'(k * 10);
      end
    end
  end

  always_comb begin
    item_o.err    = err2_q;
    item_o.dig[0] = th2_q;
    item_o.dig[1] = hu2_q;
    item_o.dig[2] = te2;
    item_o.dig[3] = DigitW'(rem2_q - sub2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      val0_q <= value_i;
    end
    if (rdy1) begin
      err1_q <= err0;
      th1_q  <= th0;
      rem1_q <= 10'(val0_q - sub0);
    end
    if (rdy2) begin
      err2_q <= err1_q;
      th2_q  <= th1_q;
      hu2_q  <= hu1;
      rem2_q <= 7'(rem1_q - sub1);
    end
  end

endmodule

`default_nettype wire

/* src/i2r_fifo.sv */
// ----------------------------------------------------------------------------
// i2r_fifo
// Short queue of classified values between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_fifo import i2r_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       avail_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

/* src/i2r_back.sv */
// ----------------------------------------------------------------------------
// i2r_back
// Character sequencer: walks the digits of one value and drives one Roman
// numeral character per cycle into the output register while it holds a value.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_back import i2r_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 strobe_o,
  output logic [SymW-1:0]      symbol_o,
  output logic                 last_o,
  output logic                 error_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic                   err_q;
  digit_t [NumDigits-1:0] dig_q;
  logic [1:0]             pos_q, idx_q;

  digit_t     cur_dig;
  logic [2:0] cur_len;
  logic       at_end, later;
  logic [1:0] nxt_pos, first_pos;
  logic       done_now, pop;

  logic                   strobe_q;
  logic [SymW-1:0]        symbol_q;
  logic                   last_q, error_q;

  assign cur_dig = dig_q[pos_q];
  assign cur_len = digit_len(cur_dig);
  assign at_end  = ({1'b0, idx_q} == (cur_len - 3'd1));

  // next nonzero digit after the current position
  always_comb begin
    later   = 1'b0;
    nxt_pos = pos_q;
    for (int k = NumDigits - 1; k >= 0; k--) begin
      if ((2'(k) > pos_q) && (dig_q[k] != '0)) begin
        later   = 1'b1;
        nxt_pos = 2'(k);
      end
    end
  end

  // first nonzero digit of the item at the queue head
  always_comb begin
    first_pos = '0;
    for (int k = NumDigits - 1; k >= 0; k--) begin
      if (item_i.dig[k] != '0) first_pos = 2'(k);
    end
  end

  assign done_now = (state_q == ST_RUN) && (err_q || (at_end && !later));
  assign pop      = avail_i && ((state_q == ST_IDLE) || done_now);
  assign pop_o    = pop;

  always_comb begin
    state_d = state_q;
    if (pop) begin
      state_d = ST_RUN;
    end else if (done_now) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == ST_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      err_q <= item_i.err;
      dig_q <= item_i.dig;
      pos_q <= first_pos;
      idx_q <= '0;
    end else if (state_q == ST_RUN) begin
      if (at_end) begin
        pos_q <= nxt_pos;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
    symbol_q <= err_q ? ChNone : symbol_of(pos_q, digit_kind(cur_dig, idx_q));
    last_q   <= err_q || (at_end && !later);
    error_q  <= err_q;
  end

  assign strobe_o = strobe_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;
  assign error_o  = error_q;

endmodule

`default_nettype wire
